// ===== rtl/core/class_pattern_stream_matcher_defines.svh =====
// assertion macros used by the checker of the matcher
`ifndef CLASS_PATTERN_STREAM_MATCHER_DEFINES_SVH
`define CLASS_PATTERN_STREAM_MATCHER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CPSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpsm assertion failed");

// consequent must hold in the cycle after the antecedent
`define CPSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpsm assertion failed");

`endif

// ===== rtl/core/cpsm_pkg.sv =====
package cpsm_pkg;

   localparam int KIND_W  = 2;
   localparam int POS_W   = 6;
   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 16;
   localparam int LEN_W   = 7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_MAP   = 2'd2,
      KIND_TEXT  = 2'd3
   } kind_type;

   // one classified item as it waits between front and back
   typedef struct packed {
      kind_type               op;
      logic [CHAR_W-1:0]      mask_char;
      logic [CHAR_W-1:0]      src_char;
      logic [POS_W-1:0]       position;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } push_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// ===== rtl/core/cpsm_if.sv =====
interface cpsm_req_if;
   logic                          valid;
   logic                          ready;
   logic [cpsm_pkg::KIND_W-1:0]   kind;
   logic [cpsm_pkg::POS_W-1:0]    position;
   logic [cpsm_pkg::CHAR_W-1:0]   first_char;
   logic [cpsm_pkg::CHAR_W-1:0]   second_char;

   modport source (output valid, output kind, output position, output first_char,
                   output second_char, input ready);
   modport sink   (input valid, input kind, input position, input first_char,
                   input second_char, output ready);
endinterface

interface cpsm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          match_here;
   logic                          found;
   logic [cpsm_pkg::COUNT_W-1:0]  text_count;

   modport source (output valid, output match_here, output found, output text_count,
                   input ready);
   modport sink   (input valid, input match_here, input found, input text_count,
                    output ready);
endinterface

// ===== rtl/core/class_pattern_stream_matcher.sv =====
// Streaming shift-and matcher with per-position character classes. Every request
// transfer (clear, pattern load, mapping, text character) yields exactly one response
// transfer, in order. Sustained rate is one item per clock in both directions while the
// response side is ready; a response passes through the front queue, then the commit
// stage behind the registered read of the mask table, then the result register.
// The rate is set by the mask table, which has one read and one write port: each
// item reads its entry at issue and writes it back at commit, with a bypass of the
// last write. pattern_length is taken from csr_write_data and may only change while idle.
module class_pattern_stream_matcher #(
   parameter int PATTERN_MAX   = 64,
   parameter int ALPHABET_SIZE = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [cpsm_pkg::LEN_W-1:0]    csr_write_data,
   cpsm_req_if.sink                      req_ch,
   cpsm_rsp_if.source                    rsp_ch
);

   cpsm_pkg::push_type push;
   cpsm_pkg::head_type head;
   logic               queue_full;
   logic               pop;

   cpsm_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   cpsm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   cpsm_back #(
      .PATTERN_MAX   (PATTERN_MAX),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .head           (head),
      .pop            (pop),
      .rsp_ch         (rsp_ch)
   );

endmodule

// ===== rtl/core/cpsm_front.sv =====
module cpsm_front (
   cpsm_req_if.sink            req_ch,
   input  logic                queue_full,
   output cpsm_pkg::push_type  push
);

   cpsm_pkg::kind_type op;

   assign op            = cpsm_pkg::kind_type'(req_ch.kind);
   assign req_ch.ready  = !queue_full;

   always_comb begin
      push.push           = req_ch.valid && !queue_full;
      push.item.op        = op;
      // a mapping addresses the mask of its replacement, everything else that of its first char
      push.item.mask_char = (op == cpsm_pkg::KIND_MAP) ? req_ch.second_char
                                                        : req_ch.first_char;
      push.item.src_char  = req_ch.first_char;
      push.item.position  = req_ch.position;
   end

endmodule

// ===== rtl/core/cpsm_queue.sv =====
module cpsm_queue (
   input  logic                clock,
   input  logic                reset,
   input  cpsm_pkg::push_type  push,
   input  logic                pop,
   output logic                full,
   output cpsm_pkg::head_type  head
);

   localparam int PW = cpsm_pkg::QPTR_W;

   cpsm_pkg::item_type entry_ff [cpsm_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full       = (count_ff == (PW+1)'(cpsm_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];
   assign do_push    = push.push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(cpsm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(cpsm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// ===== rtl/core/cpsm_back.sv =====
module cpsm_back #(
   parameter int PATTERN_MAX   = 64,
   parameter int ALPHABET_SIZE = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [cpsm_pkg::LEN_W-1:0]    csr_write_data,
   input  cpsm_pkg::head_type            head,
   output logic                          pop,
   cpsm_rsp_if.source                    rsp_ch
);

   localparam int PW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int AW = $clog2(ALPHABET_SIZE);
   localparam int LW = cpsm_pkg::LEN_W;
   localparam int CW = cpsm_pkg::CHAR_W;
   localparam int NW = cpsm_pkg::COUNT_W;

   // configuration
   logic [LW-1:0] length_ff;
   logic [LW-1:0] len_eff;
   logic [PATTERN_MAX-1:0] len_mask;
   logic [PATTERN_MAX-1:0] top_mask;

   // pattern store and mask table
   logic [CW-1:0]          pattern_ff [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] mask_mem   [ALPHABET_SIZE];
   logic [PATTERN_MAX-1:0] rdata_ff;
   logic [ALPHABET_SIZE-1:0] valid_ff, valid_in;

   // last mask write, bypassed to a read issued in the same cycle
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]          fwd_addr_ff, fwd_addr_in;
   logic [PATTERN_MAX-1:0] fwd_data_ff, fwd_data_in;

   // issue side
   logic                   pos_ok;
   logic                   addr_ok;
   logic [PATTERN_MAX-1:0] hits;
   logic [PATTERN_MAX-1:0] issue_bits;

   // commit stage
   logic                   b_valid_ff, b_valid_in;
   cpsm_pkg::kind_type     b_op_ff;
   logic [AW-1:0]          b_addr_ff;
   logic                   b_addr_ok_ff;
   logic [PATTERN_MAX-1:0] b_bits_ff;
   logic                   b_adv;

   logic [PATTERN_MAX-1:0] stored;
   logic [PATTERN_MAX-1:0] cur_mask;
   logic [PATTERN_MAX-1:0] act_next;
   logic                   mem_we;
   logic [PATTERN_MAX-1:0] wr_data;

   // matcher state
   logic [PATTERN_MAX-1:0] active_ff, active_in;
   logic                   found_ff, found_in;
   logic [NW-1:0]          count_ff, count_in;
   logic                   match_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_match_ff;
   logic                   rsp_found_ff;
   logic [NW-1:0]          rsp_count_ff;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.match_here = rsp_match_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.text_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LW'(1);
      end else if (csr_write_en) begin
         length_ff <= csr_write_data;
      end
   end

   always_comb begin
      priority if (length_ff == '0) begin
         len_eff = LW'(1);
      end else if (length_ff > LW'(PATTERN_MAX)) begin
         len_eff = LW'(PATTERN_MAX);
      end else begin
         len_eff = length_ff;
      end
      for (int i = 0; i < PATTERN_MAX; i++) begin
         len_mask[i] = (LW'(i) < len_eff);
         top_mask[i] = (LW'(i) == len_eff - 1'b1);
      end
   end

   // ---------------- issue: pop from the queue and read the mask table
   assign b_adv  = b_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign pop    = head.valid && (!b_valid_ff || b_adv);

   assign pos_ok  = ({1'b0, head.item.position} < (cpsm_pkg::POS_W+1)'(PATTERN_MAX));
   assign addr_ok = ({1'b0, head.item.mask_char} < (CW+1)'(ALPHABET_SIZE));

   always_comb begin
      for (int p = 0; p < PATTERN_MAX; p++) begin
         hits[p] = (pattern_ff[p] == head.item.src_char);
      end
      unique case (head.item.op)
         cpsm_pkg::KIND_LOAD: begin
            issue_bits = pos_ok ? (PATTERN_MAX'(1) << head.item.position[PW-1:0]) : '0;
         end
         cpsm_pkg::KIND_MAP: begin
            issue_bits = hits;
         end
         default: begin
            issue_bits = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop && head.item.op == cpsm_pkg::KIND_LOAD && pos_ok) begin
         pattern_ff[head.item.position[PW-1:0]] <= head.item.src_char;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mask_mem[b_addr_ff] <= wr_data;
      end
      if (pop) begin
         rdata_ff <= mask_mem[head.item.mask_char[AW-1:0]];
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (pop) begin
         b_valid_in = 1'b1;
      end else if (b_adv) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_op_ff      <= head.item.op;
         b_addr_ff    <= head.item.mask_char[AW-1:0];
         b_addr_ok_ff <= addr_ok;
         b_bits_ff    <= issue_bits;
      end
   end

   // ---------------- commit: update the table and the active vector
   always_comb begin
      stored   = (fwd_valid_ff && fwd_addr_ff == b_addr_ff) ? fwd_data_ff : rdata_ff;
      // an entry not written since the last clear reads as zero
      cur_mask = (b_addr_ok_ff && valid_ff[b_addr_ff]) ? stored : '0;
      wr_data  = cur_mask | b_bits_ff;
      mem_we   = b_adv && (b_op_ff == cpsm_pkg::KIND_LOAD || b_op_ff == cpsm_pkg::KIND_MAP)
                 && b_addr_ok_ff && (b_bits_ff != '0);
      act_next = ((active_ff << 1) | PATTERN_MAX'(1)) & cur_mask & len_mask;

      active_in    = active_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      match_in     = 1'b0;
      valid_in     = valid_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;

      unique case (b_op_ff)
         cpsm_pkg::KIND_CLEAR: begin
            active_in    = '0;
            found_in     = 1'b0;
            count_in     = '0;
            valid_in     = '0;
            fwd_valid_in = 1'b0;
         end
         cpsm_pkg::KIND_LOAD, cpsm_pkg::KIND_MAP: begin
            if (mem_we) begin
               valid_in[b_addr_ff] = 1'b1;
               fwd_valid_in        = 1'b1;
               fwd_addr_in         = b_addr_ff;
               fwd_data_in         = wr_data;
            end
         end
         cpsm_pkg::KIND_TEXT: begin
            active_in = act_next;
            match_in  = |(act_next & top_mask);
            found_in  = found_ff || match_in;
            count_in  = (count_ff == '1) ? count_ff : count_ff + 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (b_adv) begin
         active_ff    <= active_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         fwd_addr_ff <= fwd_addr_in;
         fwd_data_ff <= fwd_data_in;
      end
   end

   // ---------------- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         rsp_match_ff <= match_in;
         rsp_found_ff <= found_in;
         rsp_count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/cpsm_checker.sv =====
`include "class_pattern_stream_matcher_defines.svh"

module cpsm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          match_here,
   input logic                          found,
   input logic [cpsm_pkg::COUNT_W-1:0]  text_count
);

   // a stalled response keeps its payload
   `CPSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(match_here) && $stable(found) && $stable(text_count))

   // a match always raises the sticky flag
   `CPSM_ASSERT_SAME(a_match_found, clock, reset, rsp_valid && match_here, found)

   // a match needs at least one text character since the last clear
   `CPSM_ASSERT_SAME(a_found_count, clock, reset, rsp_valid && found, text_count != '0)

   // nothing is offered right after reset
   `CPSM_ASSERT_SAME(a_idle_after_reset, clock, reset, $fell(reset), !rsp_valid)

endmodule

bind class_pattern_stream_matcher cpsm_checker u_cpsm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .match_here (rsp_ch.match_here),
   .found      (rsp_ch.found),
   .text_count (rsp_ch.text_count)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PRINT_LIMIT    = 50;
   localparam int POS_W          = cpsm_pkg::POS_W;
   localparam int CHAR_W         = cpsm_pkg::CHAR_W;
   localparam int COUNT_W        = cpsm_pkg::COUNT_W;
   localparam int LEN_W          = cpsm_pkg::LEN_W;

   typedef struct packed {
      logic               match_here;
      logic               found;
      logic [COUNT_W-1:0] text_count;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [LEN_W-1:0] csr_write_data;

   cpsm_req_if req_ch();
   cpsm_rsp_if rsp_ch();

   class_pattern_stream_matcher dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch)
   );

   always #5 clock = ~clock;

   // matcher state as the testbench predicts it
   logic [CHAR_W-1:0] pat_chars [64];
   logic [63:0]       class_mask [256];
   bit                class_valid [256];
   logic [63:0]       active_bits;
   bit                found_seen;
   logic [COUNT_W-1:0] text_seen;
   int unsigned       pat_len = 1;

   scan_result_type expected_scans [$];

   int unsigned mismatches = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned hold_off_cycles = 0;
   bit          gaps_on = 1'b1;

   function automatic logic [63:0] class_bits(logic [CHAR_W-1:0] c);
      return class_valid[c] ? class_mask[c] : 64'd0;
   endfunction

   // an entry with its valid bit low is replaced, not merged
   function automatic void add_class_bits(logic [CHAR_W-1:0] c, logic [63:0] bits);
      class_mask[c]  = class_bits(c) | bits;
      class_valid[c] = 1'b1;
   endfunction

   function automatic scan_result_type predict_scan(cpsm_pkg::kind_type kind,
                                                    logic [POS_W-1:0] pos,
                                                    logic [CHAR_W-1:0] c1,
                                                    logic [CHAR_W-1:0] c2);
      scan_result_type r;
      logic [63:0]     hits;
      logic [63:0]     len_bits;
      r = '0;
      case (kind)
         cpsm_pkg::KIND_CLEAR: begin
            foreach (class_valid[i]) class_valid[i] = 1'b0;
            active_bits = '0;
            found_seen  = 1'b0;
            text_seen   = '0;
         end
         cpsm_pkg::KIND_LOAD: begin
            pat_chars[pos] = c1;
            add_class_bits(c1, 64'd1 << pos);
         end
         cpsm_pkg::KIND_MAP: begin
            hits = '0;
            for (int p = 0; p < 64; p++)
               if (pat_chars[p] == c1) hits[p] = 1'b1;
            if (hits != '0) add_class_bits(c2, hits);
         end
         default: begin
            len_bits    = (pat_len >= 64) ? '1 : ((64'd1 << pat_len) - 64'd1);
            active_bits = ((active_bits << 1) | 64'd1) & class_bits(c1) & len_bits;
            r.match_here = active_bits[pat_len-1];
            if (r.match_here) found_seen = 1'b1;
            if (text_seen != '1) text_seen++;
         end
      endcase
      r.found      = found_seen;
      r.text_count = text_seen;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(cpsm_pkg::kind_type kind, logic [POS_W-1:0] pos,
                            logic [CHAR_W-1:0] c1, logic [CHAR_W-1:0] c2);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
               req_ch.valid = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
      req_ch.valid       = 1'b1;
      req_ch.kind        = kind;
      req_ch.position    = pos;
      req_ch.first_char  = c1;
      req_ch.second_char = c2;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      expected_scans = {expected_scans, predict_scan(kind, pos, c1, c2)};
      burst_left--;
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid = 1'b0;
      while (expected_scans.size() != 0) @(negedge clock);
   endtask

   task automatic set_pattern_length(int unsigned len);
      int unsigned eff;
      drain_results();
      csr_write_data = LEN_W'(len);
      csr_write_en   = 1'b1;
      @(negedge clock);
      csr_write_en   = 1'b0;
      // zero acts as one, anything above the maximum as the maximum
      eff = len & 32'd127;
      if (eff == 0) eff = 1;
      if (eff > 64) eff = 64;
      pat_len = eff;
   endtask

   // fills every pattern position, streams the whole 64-character pattern, then two more characters
   task automatic test_full_length();
      logic [CHAR_W-1:0] c;
      set_pattern_length(64);
      send_item(cpsm_pkg::KIND_CLEAR, 6'h3F, 8'hFF, 8'hFF);
      for (int p = 0; p < 64; p++) begin
         c = (p == 63) ? 8'hFF : CHAR_W'(p * 4);
         send_item(cpsm_pkg::KIND_LOAD, POS_W'(p), c, 8'h00);
      end
      for (int p = 0; p < 64; p++) begin
         c = (p == 63) ? 8'hFF : CHAR_W'(p * 4);
         send_item(cpsm_pkg::KIND_TEXT, 6'h00, c, 8'h00);
      end
      send_item(cpsm_pkg::KIND_TEXT, 6'h3F, 8'h00, 8'hFF);
      send_item(cpsm_pkg::KIND_TEXT, 6'h15, 8'h04, 8'hAA);
   endtask

   task automatic test_class_rules();
      set_pattern_length(3);
      send_item(cpsm_pkg::KIND_CLEAR, 6'h00, 8'h00, 8'h00);
      // mapping before the load must not apply to it
      send_item(cpsm_pkg::KIND_MAP, 6'h2A, 8'h62, 8'h00);
      send_item(cpsm_pkg::KIND_LOAD, 6'd0, 8'h61, 8'h00);
      send_item(cpsm_pkg::KIND_LOAD, 6'd1, 8'h62, 8'h00);
      send_item(cpsm_pkg::KIND_LOAD, 6'd2, 8'h63, 8'h00);
      send_item(cpsm_pkg::KIND_MAP, 6'h15, 8'h62, 8'hFF);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'h61, 8'h00);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'hFF, 8'h00);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'h63, 8'h00);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'h61, 8'h00);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'h00, 8'h00);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'h63, 8'h00);
      // reload without clear: position accepts both characters
      send_item(cpsm_pkg::KIND_LOAD, 6'd2, 8'h00, 8'hFF);
      send_item(cpsm_pkg::KIND_TEXT, 6'h3F, 8'h61, 8'hFF);
      send_item(cpsm_pkg::KIND_TEXT, 6'h3F, 8'h62, 8'hFF);
      send_item(cpsm_pkg::KIND_TEXT, 6'h3F, 8'h00, 8'hFF);
      send_item(cpsm_pkg::KIND_TEXT, 6'h3F, 8'h61, 8'hFF);
      send_item(cpsm_pkg::KIND_TEXT, 6'h3F, 8'h62, 8'hFF);
      // load between text characters takes effect on the next one
      send_item(cpsm_pkg::KIND_LOAD, 6'd2, 8'h7A, 8'h00);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'h7A, 8'h00);
   endtask

   task automatic test_clear_keeps_store();
      // a length of zero acts as one
      set_pattern_length(0);
      send_item(cpsm_pkg::KIND_CLEAR, 6'h00, 8'h00, 8'h00);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'h61, 8'h00);
      // pattern store survives the clear, so the mapping still finds 'a'
      send_item(cpsm_pkg::KIND_MAP, 6'h00, 8'h61, 8'h71);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'h71, 8'h00);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'h61, 8'h00);
      send_item(cpsm_pkg::KIND_CLEAR, 6'h00, 8'h00, 8'h00);
      send_item(cpsm_pkg::KIND_TEXT, 6'h00, 8'h71, 8'h00);
   endtask

   task automatic test_input_backpressure();
      gaps_on = 1'b0;
      hold_off_cycles = 400;
      send_item(cpsm_pkg::KIND_LOAD, 6'd0, 8'h71, 8'h00);
      repeat (48) send_item(cpsm_pkg::KIND_TEXT, POS_W'($urandom),
                            CHAR_W'(8'h70 + $urandom_range(0, 2)), CHAR_W'($urandom));
      drain_results();
   endtask

   task automatic test_random_sequences(int unsigned target);
      int unsigned goal;
      int unsigned len;
      int unsigned span;
      int unsigned n_maps;
      int unsigned n_text;
      int unsigned emitted;
      int unsigned pick;
      logic [CHAR_W-1:0] base;
      logic [CHAR_W-1:0] c;
      logic [CHAR_W-1:0] alt;
      logic [CHAR_W-1:0] seq_chars [64];
      logic [CHAR_W-1:0] map_from [$];
      logic [CHAR_W-1:0] map_to [$];
      logic [CHAR_W-1:0] alts [$];
      goal = items_sent + target;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 15);
         len  = (pick == 0) ? 64 : (pick < 3) ? $urandom_range(9, 63) : $urandom_range(1, 8);
         gaps_on = ($urandom_range(0, 3) != 0);
         set_pattern_length(len);
         send_item(cpsm_pkg::KIND_CLEAR, POS_W'($urandom), CHAR_W'($urandom),
                   CHAR_W'($urandom));
         base = CHAR_W'($urandom);
         span = $urandom_range(1, 4);
         map_from.delete();
         map_to.delete();
         for (int p = 0; p < len; p++) begin
            seq_chars[p] = CHAR_W'(base + $urandom_range(0, span - 1));
            send_item(cpsm_pkg::KIND_LOAD, POS_W'(p), seq_chars[p], CHAR_W'($urandom));
         end
         n_maps = $urandom_range(0, 3);
         for (int m = 0; m < n_maps; m++) begin
            c   = seq_chars[$urandom_range(0, len - 1)];
            alt = $urandom_range(0, 1) ? CHAR_W'(base + span) : CHAR_W'($urandom);
            map_from = {map_from, c};
            map_to   = {map_to, alt};
            send_item(cpsm_pkg::KIND_MAP, POS_W'($urandom), c, alt);
         end
         n_text  = len + $urandom_range(4, 40);
         emitted = 0;
         while (emitted < n_text) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               send_item(cpsm_pkg::kind_type'($urandom_range(0, 2)), POS_W'($urandom),
                         CHAR_W'($urandom), CHAR_W'($urandom));
            end else if (pick < 12) begin
               // one pattern instance, some positions taken from their class
               for (int p = 0; p < len; p++) begin
                  c = seq_chars[p];
                  if ($urandom_range(0, 3) == 0) begin
                     alts.delete();
                     foreach (map_from[i])
                        if (map_from[i] == c) alts = {alts, map_to[i]};
                     if (alts.size() != 0) c = alts[$urandom_range(0, alts.size() - 1)];
                  end
                  if ($urandom_range(0, 31) == 0) c = CHAR_W'($urandom);
                  send_item(cpsm_pkg::KIND_TEXT, POS_W'($urandom), c, CHAR_W'($urandom));
               end
               emitted += len;
            end else begin
               send_item(cpsm_pkg::KIND_TEXT, POS_W'($urandom),
                         CHAR_W'(base + $urandom_range(0, span)), CHAR_W'($urandom));
               emitted++;
            end
         end
      end
   endtask

   initial begin : stimulus
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_write_data     = '0;
      req_ch.valid       = 1'b0;
      req_ch.kind        = '0;
      req_ch.position    = '0;
      req_ch.first_char  = '0;
      req_ch.second_char = '0;
      active_bits        = '0;
      found_seen         = 1'b0;
      text_seen          = '0;
      foreach (class_valid[i]) class_valid[i] = 1'b0;
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_full_length();
      test_class_rules();
      test_clear_keeps_store();
      test_input_backpressure();
      test_random_sequences(1600);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // response side: rerolls its ready pattern whenever its slot counter wraps to zero
   initial begin : rsp_pacing
      logic [15:0] ready_pattern;
      int unsigned slot;
      rsp_ch.ready  = 1'b0;
      ready_pattern = '1;
      slot          = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            hold_off_cycles--;
            rsp_ch.ready = 1'b0;
         end else begin
            if (slot == 0) begin
               case ($urandom_range(0, 3))
                  0: ready_pattern = '1;
                  1: ready_pattern = 16'($urandom);
                  2: ready_pattern = 16'($urandom | $urandom);
                  default: ready_pattern = 16'($urandom & $urandom);
               endcase
            end
            rsp_ch.ready = ready_pattern[slot[3:0]];
            slot = (slot + 1) % 64;
         end
      end
   end

   always @(posedge clock) begin : scan_check
      scan_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_scans.size() == 0) begin
            report_mismatch("unexpected response transfer", longint'(1), longint'(0));
         end else begin
            want = expected_scans.pop_front();
            if (rsp_ch.match_here !== want.match_here)
               report_mismatch("match_here", longint'(rsp_ch.match_here),
                               longint'(want.match_here));
            if (rsp_ch.found !== want.found)
               report_mismatch("found", longint'(rsp_ch.found), longint'(want.found));
            if (rsp_ch.text_count !== want.text_count)
               report_mismatch("text_count", longint'(rsp_ch.text_count),
                               longint'(want.text_count));
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule
